/* rtl/core/pwc_pkg.sv */
`default_nettype none

package pwc_pkg;

  // Vertex coordinates, two's complement
  typedef logic signed [15:0] coord_t;
  // Window bounds, unsigned
  typedef logic [15:0] bound_t;
  // Common signed range for comparing coordinates against bounds
  typedef logic signed [16:0] ext_t;
  // Difference between a bound and a coordinate
  typedef logic signed [17:0] diff_t;
  // One partial cross product and the full cross product
  typedef logic signed [34:0] prod_t;
  typedef logic signed [35:0] cross_t;
  // Winding number, wraps modulo 2^16
  typedef logic [15:0] wind_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  // Inclusive window bounds
  typedef struct packed {
    bound_t x0;
    bound_t x1;
    bound_t y0;
    bound_t y1;
  } win_bounds_t;

  // Sideband that travels with each vertex down the pipeline
  typedef struct packed {
    logic valid;
    logic last;
    logic first;
    logic in_win;
    logic a_on;
    logic b_on;
  } ctl_t;

  // Outcome of one polygon edge against the window
  typedef struct packed {
    logic hit;
    logic inc;
    logic dec;
  } edge_res_t;

  typedef logic [1:0] relation_t;

  localparam relation_t REL_OUTSIDE  = 2'd0;
  localparam relation_t REL_ENCLOSES = 2'd1;
  localparam relation_t REL_OTHER    = 2'd2;

  function automatic ext_t ext_pt(coord_t v);
    return {v[15], v};
  endfunction

  function automatic ext_t ext_bd(bound_t v);
    return {1'b0, v};
  endfunction

endpackage

`default_nettype wire

/* rtl/core/polygon_window_classifier.sv */
`default_nettype none

// Channel   Handshake                     Payload
// vertex    vertex_valid / vertex_ready   vertex_x, vertex_y, last_vertex, window_*
// result    result_valid / result_ready   relation
//
// One vertex is taken every cycle unless a result is held; the edge test runs through
// four register stages: the front stage, the product stage, the edge result and the output.
// Each edge has its own eight 18 x 18 bit products, so no vertex waits on another.
// Reset (rst, synchronous) clears the polygon tracking, the pipeline and the result register.
// A held result stalls the whole pipeline; a skid stage keeps vertex_ready a register output.

module polygon_window_classifier import pwc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        vertex_valid,
  output logic        vertex_ready,
  input  logic [15:0] vertex_x,
  input  logic [15:0] vertex_y,
  input  logic        last_vertex,
  input  logic [15:0] window_x_begin,
  input  logic [15:0] window_x_end,
  input  logic [15:0] window_y_begin,
  input  logic [15:0] window_y_end,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  relation
);

  logic        en;
  point_t      vtx;
  win_bounds_t raw_win;
  ctl_t        s1_ctl;
  win_bounds_t s1_win;
  point_t      s1_a0;
  point_t      s1_a1;
  point_t      s1_b0;
  point_t      s1_b1;
  edge_res_t   res_a;
  edge_res_t   res_b;

  // Advance the pipeline unless a result is held
  assign en = !result_valid || result_ready;

  // Inclusive window bounds
  assign vtx.x      = coord_t'(vertex_x);
  assign vtx.y      = coord_t'(vertex_y);
  assign raw_win.x0 = window_x_begin;
  assign raw_win.x1 = window_x_end - 16'd1;
  assign raw_win.y0 = window_y_begin;
  assign raw_win.y1 = window_y_end - 16'd1;

  pwc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .vertex_valid (vertex_valid),
    .vertex_ready (vertex_ready),
    .vtx          (vtx),
    .last_vertex  (last_vertex),
    .raw_win      (raw_win),
    .s1_ctl       (s1_ctl),
    .s1_win       (s1_win),
    .s1_a0        (s1_a0),
    .s1_a1        (s1_a1),
    .s1_b0        (s1_b0),
    .s1_b1        (s1_b1)
  );

  // Edge from the previous vertex
  pwc_edge u_edge_a (
    .clk (clk),
    .en  (en),
    .win (s1_win),
    .pa  (s1_a0),
    .pb  (s1_a1),
    .res (res_a)
  );

  // Closing edge back to the first vertex
  pwc_edge u_edge_b (
    .clk (clk),
    .en  (en),
    .win (s1_win),
    .pa  (s1_b0),
    .pb  (s1_b1),
    .res (res_b)
  );

  pwc_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .s1_ctl       (s1_ctl),
    .res_a        (res_a),
    .res_b        (res_b),
    .result_valid (result_valid),
    .relation     (relation)
  );

endmodule

`default_nettype wire

/* rtl/core/pwc_front.sv */
`default_nettype none

module pwc_front import pwc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        vertex_valid,
  output logic        vertex_ready,
  input  point_t      vtx,
  input  logic        last_vertex,
  input  win_bounds_t raw_win,
  output ctl_t        s1_ctl,
  output win_bounds_t s1_win,
  output point_t      s1_a0,
  output point_t      s1_a1,
  output point_t      s1_b0,
  output point_t      s1_b1
);

  logic        skid_valid;
  point_t      skid_pt;
  logic        skid_last;
  win_bounds_t skid_win;

  logic        src_valid;
  point_t      src_pt;
  logic        src_last;
  win_bounds_t src_win;
  logic        take;

  logic        mid_polygon;
  point_t      first_pt;
  point_t      prev_pt;
  win_bounds_t win;

  win_bounds_t cur_win;
  point_t      cur_first;
  logic        in_win;
  ext_t        px;
  ext_t        py;

  // Skid stage: holds one transfer while the pipeline is stalled
  assign vertex_ready = !skid_valid;
  assign src_valid    = skid_valid || vertex_valid;
  assign src_pt       = skid_valid ? skid_pt   : vtx;
  assign src_last     = skid_valid ? skid_last : last_vertex;
  assign src_win      = skid_valid ? skid_win  : raw_win;
  assign take         = en && src_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (en) begin
      skid_valid <= 1'b0;
    end else if (vertex_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && vertex_valid && !skid_valid) begin
      skid_pt   <= vtx;
      skid_last <= last_vertex;
      skid_win  <= raw_win;
    end
  end

  // Window and first vertex as seen by this vertex
  assign cur_win   = mid_polygon ? win : src_win;
  assign cur_first = mid_polygon ? first_pt : src_pt;

  // First vertex inside the inclusive window
  assign px     = ext_pt(src_pt.x);
  assign py     = ext_pt(src_pt.y);
  assign in_win = (px >= ext_bd(src_win.x0)) && (px <= ext_bd(src_win.x1)) &&
                  (py >= ext_bd(src_win.y0)) && (py <= ext_bd(src_win.y1));

  // Polygon tracking: latch window and first vertex, advance previous vertex
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_polygon <= 1'b0;
    end else if (take) begin
      mid_polygon <= !src_last;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      prev_pt <= src_pt;
      if (!mid_polygon) begin
        win      <= src_win;
        first_pt <= src_pt;
      end
    end
  end

  // Stage register: the edge from the previous vertex and the closing edge this vertex brings in
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else if (en) begin
      s1_ctl.valid  <= src_valid;
      s1_ctl.last   <= src_last;
      s1_ctl.first  <= !mid_polygon;
      s1_ctl.in_win <= in_win;
      s1_ctl.a_on   <= mid_polygon;
      s1_ctl.b_on   <= src_last;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_win <= cur_win;
      s1_a0  <= prev_pt;
      s1_a1  <= src_pt;
      s1_b0  <= src_pt;
      s1_b1  <= cur_first;
    end
  end

  a_mid_falls_on_last: assert property (@(posedge clk) disable iff (rst)
    $fell(mid_polygon) |-> $past(take && src_last))
    else $error("polygon closed without a last vertex");

  a_skid_fills_on_stall: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !$past(skid_valid) |-> $past(!en))
    else $error("skid stage filled while the pipeline advanced");

endmodule

`default_nettype wire

/* rtl/core/pwc_edge.sv */
`default_nettype none

module pwc_edge import pwc_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  win_bounds_t win,
  input  point_t      pa,
  input  point_t      pb,
  output edge_res_t   res
);

  ext_t  ax, ay, bx, by;
  ext_t  cx [4];
  ext_t  cy [4];
  diff_t dxab, dyab;
  diff_t dcx [4];
  diff_t dcy [4];
  logic  wf [4];
  logic  wuse_y [4];
  ext_t  wc [4];

  // Product stage
  prod_t p1 [4];
  prod_t p2 [4];
  logic  cin [4];
  logic  a_on [4];
  logic  b_on [4];
  logic  wz_a [4];
  logic  wz_b [4];
  logic  wd [4];
  logic  a_le;
  logic  b_gt;

  logic  cin_c [4];
  logic  a_on_c [4];
  logic  b_on_c [4];
  logic  wz_a_c [4];
  logic  wz_b_c [4];
  logic  wd_c [4];

  cross_t cr [4];
  logic   neg [4];
  logic   zro [4];
  edge_res_t res_c;

  // Window corners: low/low, low/high, high/high, high/low
  always_comb begin
    ax = ext_pt(pa.x);
    ay = ext_pt(pa.y);
    bx = ext_pt(pb.x);
    by = ext_pt(pb.y);
    cx[0] = ext_bd(win.x0);
    cy[0] = ext_bd(win.y0);
    cx[1] = ext_bd(win.x0);
    cy[1] = ext_bd(win.y1);
    cx[2] = ext_bd(win.x1);
    cy[2] = ext_bd(win.y1);
    cx[3] = ext_bd(win.x1);
    cy[3] = ext_bd(win.y0);
    dxab  = diff_t'(bx) - diff_t'(ax);
    dyab  = diff_t'(by) - diff_t'(ay);
    for (int k = 0; k < 4; k++) begin
      dcx[k] = diff_t'(cx[k]) - diff_t'(ax);
      dcy[k] = diff_t'(cy[k]) - diff_t'(ay);
    end
  end

  // Window edge k runs from corner k to the next; a vertical edge tests x, else y
  always_comb begin
    wf[0] = (win.y0 != win.y1);
    wf[1] = (win.x0 != win.x1);
    wf[2] = (win.y0 != win.y1);
    wf[3] = (win.x0 != win.x1);
    wuse_y[0] = 1'b0;
    wuse_y[1] = 1'b1;
    wuse_y[2] = 1'b0;
    wuse_y[3] = 1'b1;
    wc[0] = ext_bd(win.x0);
    wc[1] = ext_bd(win.y1);
    wc[2] = ext_bd(win.x1);
    wc[3] = ext_bd(win.y0);
  end

  // Orientation of the endpoints against each window edge, and box tests
  always_comb begin
    logic [1:0] n;
    ext_t ra, rb;
    logic lt_a, lt_b, eq_a, eq_b;
    n    = '0;
    ra   = '0;
    rb   = '0;
    lt_a = 1'b0;
    lt_b = 1'b0;
    eq_a = 1'b0;
    eq_b = 1'b0;
    for (int k = 0; k < 4; k++) begin
      n  = 2'(k + 1);
      ra = wuse_y[k] ? ay : ax;
      rb = wuse_y[k] ? by : bx;
      lt_a = ra < wc[k];
      lt_b = rb < wc[k];
      eq_a = ra == wc[k];
      eq_b = rb == wc[k];
      wz_a_c[k] = !wf[k] || eq_a;
      wz_b_c[k] = !wf[k] || eq_b;
      wd_c[k]   = wf[k] && ((lt_a != lt_b) || (eq_a != eq_b));
      cin_c[k]  = ((cx[k] >= ax) || (cx[k] >= bx)) && ((cx[k] <= ax) || (cx[k] <= bx)) &&
                  ((cy[k] >= ay) || (cy[k] >= by)) && ((cy[k] <= ay) || (cy[k] <= by));
      a_on_c[k] = ((ax >= cx[k]) || (ax >= cx[n])) && ((ax <= cx[k]) || (ax <= cx[n])) &&
                  ((ay >= cy[k]) || (ay >= cy[n])) && ((ay <= cy[k]) || (ay <= cy[n]));
      b_on_c[k] = ((bx >= cx[k]) || (bx >= cx[n])) && ((bx <= cx[k]) || (bx <= cx[n])) &&
                  ((by >= cy[k]) || (by >= cy[n])) && ((by <= cy[k]) || (by <= cy[n]));
    end
  end

  // Product stage: partial cross products against each corner
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        p1[k]   <= prod_t'(dxab) * prod_t'(dcy[k]);
        p2[k]   <= prod_t'(dcx[k]) * prod_t'(dyab);
        cin[k]  <= cin_c[k];
        a_on[k] <= a_on_c[k];
        b_on[k] <= b_on_c[k];
        wz_a[k] <= wz_a_c[k];
        wz_b[k] <= wz_b_c[k];
        wd[k]   <= wd_c[k];
      end
      a_le <= ay <= cy[0];
      b_gt <= by > cy[0];
    end
  end

  // Turn signs, segment meet tests and winding step
  always_comb begin
    logic [1:0] n;
    logic hit;
    n   = '0;
    hit = 1'b0;
    for (int k = 0; k < 4; k++) begin
      cr[k]  = cross_t'(p1[k]) - cross_t'(p2[k]);
      neg[k] = cr[k][35];
      zro[k] = (cr[k] == '0);
    end
    for (int k = 0; k < 4; k++) begin
      n = 2'(k + 1);
      if ((((neg[k] != neg[n]) || (zro[k] != zro[n])) && wd[k]) ||
          (zro[k] && cin[k]) || (zro[n] && cin[n]) ||
          (wz_a[k] && a_on[k]) || (wz_b[k] && b_on[k])) begin
        hit = 1'b1;
      end
    end
    res_c.hit = hit;
    res_c.inc = a_le && b_gt && !neg[0] && !zro[0];
    res_c.dec = !a_le && !b_gt && neg[0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_c;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pwc_accum.sv */
`default_nettype none

module pwc_accum import pwc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  ctl_t      s1_ctl,
  input  edge_res_t res_a,
  input  edge_res_t res_b,
  output logic      result_valid,
  output relation_t relation
);

  ctl_t  ctl_p;
  ctl_t  ctl_s;
  logic  edge_hit;
  logic  first_inside;
  wind_t winding_count;

  logic      edge_hit_next;
  logic      first_inside_next;
  wind_t     winding_count_next;
  wind_t     step_a;
  wind_t     step_b;
  relation_t relation_next;

  // Delay the sideband to line up with the edge results
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_p <= '0;
      ctl_s <= '0;
    end else if (en) begin
      ctl_p <= s1_ctl;
      ctl_s <= ctl_p;
    end
  end

  // Fold both edges of this vertex into the polygon state
  always_comb begin
    step_a = '0;
    step_b = '0;
    if (ctl_s.a_on && res_a.inc) begin
      step_a = wind_t'(1);
    end else if (ctl_s.a_on && res_a.dec) begin
      step_a = '1;
    end
    if (ctl_s.b_on && res_b.inc) begin
      step_b = wind_t'(1);
    end else if (ctl_s.b_on && res_b.dec) begin
      step_b = '1;
    end
    edge_hit_next      = (ctl_s.first ? 1'b0 : edge_hit) ||
                         (ctl_s.a_on && res_a.hit) || (ctl_s.b_on && res_b.hit);
    first_inside_next  = ctl_s.first ? ctl_s.in_win : first_inside;
    winding_count_next = (ctl_s.first ? wind_t'(0) : winding_count) + step_a + step_b;
    if (edge_hit_next || first_inside_next) begin
      relation_next = REL_OTHER;
    end else if (winding_count_next != '0) begin
      relation_next = REL_ENCLOSES;
    end else begin
      relation_next = REL_OUTSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_hit      <= 1'b0;
      first_inside  <= 1'b0;
      winding_count <= '0;
    end else if (en && ctl_s.valid) begin
      edge_hit      <= edge_hit_next;
      first_inside  <= first_inside_next;
      winding_count <= winding_count_next;
    end
  end

  // Output register: one result per closed polygon
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= ctl_s.valid && ctl_s.last;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      relation <= relation_next;
    end
  end

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(ctl_s.valid && ctl_s.last))
    else $error("result raised without a last vertex");

  a_first_has_no_open_edge: assert property (@(posedge clk) disable iff (rst)
    ctl_s.valid && ctl_s.first |-> !ctl_s.a_on)
    else $error("first vertex carries an edge from a previous vertex");

endmodule

`default_nettype wire

/* sim/polygon_window_classifier_tb.sv */
`timescale 1ns / 1ps

module polygon_window_classifier_tb;
  import pwc_pkg::*;

  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 1400;

  typedef enum logic [1:0] {TURN_FLAT, TURN_CW, TURN_CCW} turn_t;
  typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_SLOW, SINK_BURSTY} sink_mode_t;

  // Raw window fields as they sit on the ports (end bounds exclusive)
  typedef struct packed {
    bound_t xb, xe, yb, ye;
  } span_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
    bound_t xb, xe, yb, ye;
  } vertex_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        vertex_valid = 1'b0;
  logic        vertex_ready;
  logic [15:0] vertex_x = '0;
  logic [15:0] vertex_y = '0;
  logic        last_vertex = 1'b0;
  logic [15:0] window_x_begin = '0;
  logic [15:0] window_x_end = 16'd1;
  logic [15:0] window_y_begin = '0;
  logic [15:0] window_y_end = 16'd1;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [1:0]  relation;

  polygon_window_classifier dut (
    .clk            (clk),
    .rst            (rst),
    .vertex_valid   (vertex_valid),
    .vertex_ready   (vertex_ready),
    .vertex_x       (vertex_x),
    .vertex_y       (vertex_y),
    .last_vertex    (last_vertex),
    .window_x_begin (window_x_begin),
    .window_x_end   (window_x_end),
    .window_y_begin (window_y_begin),
    .window_y_end   (window_y_end),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .relation       (relation)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  vertex_item_t vertex_queue[$];
  relation_t    relations_due[$];
  point_t       outline[$];
  int           fault_count = 0;
  int           results_seen = 0;
  int           cycle_count = 0;

  // Polygon tracking state of the classifier
  win_bounds_t shape_win;
  point_t      first_pt, prev_pt;
  bit          edge_touched, first_in, poly_open;
  wind_t       winding;

  // Orientation of the turn p -> q -> r
  function automatic turn_t turn_of(longint px, py, qx, qy, rx, ry);
    longint v;
    v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
    if (v == 0) return TURN_FLAT;
    return (v > 0) ? TURN_CW : TURN_CCW;
  endfunction

  // q lies in the bounding box of p and r
  function automatic bit in_box(longint px, py, qx, qy, rx, ry);
    return qx <= ((px > rx) ? px : rx) && qx >= ((px < rx) ? px : rx) &&
           qy <= ((py > ry) ? py : ry) && qy >= ((py < ry) ? py : ry);
  endfunction

  function automatic bit segments_touch(longint ax, ay, bx, by, cx, cy, dx, dy);
    turn_t t1, t2, t3, t4;
    t1 = turn_of(ax, ay, bx, by, cx, cy);
    t2 = turn_of(ax, ay, bx, by, dx, dy);
    t3 = turn_of(cx, cy, dx, dy, ax, ay);
    t4 = turn_of(cx, cy, dx, dy, bx, by);
    if (t1 != t2 && t3 != t4) return 1'b1;
    if (t1 == TURN_FLAT && in_box(ax, ay, cx, cy, bx, by)) return 1'b1;
    if (t2 == TURN_FLAT && in_box(ax, ay, dx, dy, bx, by)) return 1'b1;
    if (t3 == TURN_FLAT && in_box(cx, cy, ax, ay, dx, dy)) return 1'b1;
    if (t4 == TURN_FLAT && in_box(cx, cy, bx, by, dx, dy)) return 1'b1;
    return 1'b0;
  endfunction

  // Test one polygon edge a -> b against the window and update the winding
  function automatic void trace_edge(point_t a, point_t b);
    longint ax, ay, bx, by, x0, x1, y0, y1, side;
    longint wx[4], wy[4];
    ax = longint'($signed(a.x));
    ay = longint'($signed(a.y));
    bx = longint'($signed(b.x));
    by = longint'($signed(b.y));
    x0 = longint'(shape_win.x0);
    x1 = longint'(shape_win.x1);
    y0 = longint'(shape_win.y0);
    y1 = longint'(shape_win.y1);
    wx = '{x0, x0, x1, x1};
    wy = '{y0, y1, y1, y0};
    for (int j = 0; j < 4; j++)
      if (segments_touch(bx, by, ax, ay, wx[j], wy[j], wx[(j + 1) % 4], wy[(j + 1) % 4]))
        edge_touched = 1'b1;
    side = (bx - ax) * (y0 - ay) - (x0 - ax) * (by - ay);
    if (ay <= y0) begin
      if (by > y0 && side > 0) winding = winding + 16'd1;
    end else if (by <= y0 && side < 0) begin
      winding = winding - 16'd1;
    end
  endfunction

  // Advance the classifier by one transferred vertex
  function automatic void classify_vertex(vertex_item_t v);
    point_t p;
    longint px, py;
    p.x = v.x;
    p.y = v.y;
    if (!poly_open) begin
      shape_win.x0 = v.xb;
      shape_win.x1 = v.xe - 16'd1;
      shape_win.y0 = v.yb;
      shape_win.y1 = v.ye - 16'd1;
      first_pt = p;
      edge_touched = 1'b0;
      winding = '0;
      px = longint'($signed(v.x));
      py = longint'($signed(v.y));
      first_in = px >= longint'(shape_win.x0) && px <= longint'(shape_win.x1) &&
                 py >= longint'(shape_win.y0) && py <= longint'(shape_win.y1);
      poly_open = 1'b1;
    end else begin
      trace_edge(prev_pt, p);
    end
    prev_pt = p;
    if (v.last) begin
      trace_edge(p, first_pt);
      if (edge_touched || first_in) relations_due.push_back(REL_OTHER);
      else if (winding != 0) relations_due.push_back(REL_ENCLOSES);
      else relations_due.push_back(REL_OUTSIDE);
      poly_open = 1'b0;
    end
  endfunction

  function automatic point_t pt(int x, int y);
    point_t p;
    p.x = coord_t'((x < -32768) ? -32768 : (x > 32767) ? 32767 : x);
    p.y = coord_t'((y < -32768) ? -32768 : (y > 32767) ? 32767 : y);
    return p;
  endfunction

  function automatic span_t span(int xb, int xe, int yb, int ye);
    span_t w;
    w.xb = bound_t'(xb);
    w.xe = bound_t'(xe);
    w.yb = bound_t'(yb);
    w.ye = bound_t'(ye);
    return w;
  endfunction

  function automatic int spread(int s);
    if (s <= 0) return 0;
    return int'($urandom_range(0, 2 * s)) - s;
  endfunction

  // Queue the outline as one polygon; later vertices carry junk window fields
  task automatic queue_polygon(span_t w);
    vertex_item_t v;
    foreach (outline[i]) begin
      v.x = outline[i].x;
      v.y = outline[i].y;
      v.last = (i == outline.size() - 1);
      if (i == 0) begin
        {v.xb, v.xe, v.yb, v.ye} = w;
      end else begin
        v.xb = 16'($urandom);
        v.xe = 16'($urandom);
        v.yb = 16'($urandom);
        v.ye = 16'($urandom);
      end
      vertex_queue.push_back(v);
    end
  endtask

  task automatic random_polygon();
    span_t w;
    int r, k, xb, xe, yb, ye, cx, cy, hx, hy, rx, ry, n, t, f, x, y, jit;
    int marks[$];
    bit snap;
    // pick the window: mostly modest, some full range, some empty, some at the extremes
    r = $urandom_range(0, 99);
    xb = $urandom_range(0, 30000);
    yb = $urandom_range(0, 30000);
    xe = xb + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 3000));
    ye = yb + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 3000));
    if (r >= 70 && r < 88) begin
      xb = $urandom_range(0, 65534);
      xe = $urandom_range(xb + 1, 65535);
      yb = $urandom_range(0, 65534);
      ye = $urandom_range(yb + 1, 65535);
    end else if (r >= 88 && r < 95) begin
      if ($urandom_range(0, 1)) begin
        xb = $urandom_range(1, 65534);
        xe = $urandom_range(1, xb);
      end else begin
        yb = $urandom_range(1, 65534);
        ye = $urandom_range(1, yb);
      end
    end else if (r >= 95) begin
      xb = $urandom_range(0, 1) ? 0 : 65534;
      xe = $urandom_range(0, 1) ? 1 : 65535;
      yb = $urandom_range(0, 1) ? 0 : 65534;
      ye = $urandom_range(0, 1) ? 1 : 65535;
    end
    w = span(xb, xe, yb, ye);
    cx = (xb + xe) / 2;
    cy = (yb + ye) / 2;
    hx = (xe > xb) ? (xe - xb) / 2 : 1;
    hy = (ye > yb) ? (ye - yb) / 2 : 1;

    // pick the shape
    outline = {};
    k = $urandom_range(0, 99);
    if (k < 10) begin
      n = $urandom_range(1, 2);
      repeat (n) outline.push_back(pt(cx + spread(2 * hx + 50), cy + spread(2 * hy + 50)));
    end else if (k < 85) begin
      if (k < 45) begin
        rx = hx + $urandom_range(1, 3000);
        ry = hy + $urandom_range(1, 3000);
        cx = cx + spread(hx / 4);
        cy = cy + spread(hy / 4);
      end else if (k < 70) begin
        rx = $urandom_range(0, 2 * hx + 2);
        ry = $urandom_range(0, 2 * hy + 2);
        cx = cx + spread(hx);
        cy = cy + spread(hy);
      end else begin
        rx = $urandom_range(1, 2000);
        ry = $urandom_range(1, 2000);
        cx = cx + spread(20000);
        cy = cy + spread(20000);
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(3, 8);
      jit = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 40);
      repeat (n) marks.push_back($urandom_range(0, 4095));
      marks.sort();
      // walk the perimeter of a rectangle around the centre
      foreach (marks[i]) begin
        t = marks[i];
        f = t % 1024;
        case (t / 1024)
          0: begin x = cx - rx + (2 * rx * f) / 1024; y = cy - ry; end
          1: begin x = cx + rx; y = cy - ry + (2 * ry * f) / 1024; end
          2: begin x = cx + rx - (2 * rx * f) / 1024; y = cy + ry; end
          default: begin x = cx - rx; y = cy + ry - (2 * ry * f) / 1024; end
        endcase
        outline.push_back(pt(x + spread(jit), y + spread(jit)));
      end
    end else begin
      n = $urandom_range(1, 10);
      repeat (n) outline.push_back(pt(int'($urandom_range(0, 65535)) - 32768,
                                      int'($urandom_range(0, 65535)) - 32768));
    end

    // snap some vertices onto window bound lines for the collinear cases
    snap = ($urandom_range(0, 3) == 0);
    if (snap) begin
      foreach (outline[i]) begin
        if ($urandom_range(0, 2) == 0)
          outline[i].x = pt($urandom_range(0, 1) ? xb : xe - 1, 0).x;
        if ($urandom_range(0, 2) == 0)
          outline[i].y = pt(0, $urandom_range(0, 1) ? yb : ye - 1).y;
      end
    end
    if ($urandom_range(0, 1)) outline.reverse();
    queue_polygon(w);
  endtask

  task automatic report_fault(string want_txt, logic [1:0] got);
    if (fault_count < 10)
      $display("relation %0d: expected %s, got %0d", results_seen, want_txt, got);
    fault_count++;
  endtask

  // Sender: offer queued vertices in bursts with idle gaps between them
  vertex_item_t vertex_now;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      vertex_valid <= 1'b0;
    end else begin
      if (vertex_valid && vertex_ready) classify_vertex(vertex_now);
      if (!vertex_valid || vertex_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          vertex_valid <= 1'b0;
        end else if (vertex_queue.size() != 0) begin
          vertex_now = vertex_queue.pop_front();
          vertex_valid <= 1'b1;
          vertex_x <= vertex_now.x;
          vertex_y <= vertex_now.y;
          last_vertex <= vertex_now.last;
          window_x_begin <= vertex_now.xb;
          window_x_end <= vertex_now.xe;
          window_y_begin <= vertex_now.yb;
          window_y_end <= vertex_now.ye;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
          end
        end else begin
          vertex_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall on a pattern picked at random among open, coin, slow and bursty modes
  sink_mode_t sink_mode = SINK_OPEN;
  int sink_tick = 0;

  always @(posedge clk) begin
    sink_tick++;
    if (sink_tick % 200 == 0) sink_mode = sink_mode_t'($urandom_range(0, 3));
    case (sink_mode)
      SINK_OPEN:   result_ready <= 1'b1;
      SINK_COIN:   result_ready <= ($urandom_range(0, 2) != 0);
      SINK_SLOW:   result_ready <= (sink_tick % 4 == 0);
      SINK_BURSTY: result_ready <= (sink_tick % 16 >= 12);
      default:     result_ready <= 1'b1;
    endcase
  end

  // Check each result transfer against the oldest predicted relation
  always @(posedge clk) begin
    relation_t want;
    if (!rst && result_valid && result_ready) begin
      results_seen++;
      if (relations_due.size() == 0) begin
        report_fault("none", relation);
      end else begin
        want = relations_due.pop_front();
        if (relation !== want) report_fault($sformatf("%0d", want), relation);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    span_t box;
    int random_start;
    box = span(100, 110, 100, 110);

    // single vertex polygons: inside, outside, empty window
    outline = {pt(105, 105)};
    queue_polygon(box);
    outline = {pt(-5, -5)};
    queue_polygon(box);
    outline = {pt(40, 40)};
    queue_polygon(span(50, 50, 0, 10));
    // enclosing triangle, both orientations
    outline = {pt(-1000, -1000), pt(1000, -1000), pt(0, 1000)};
    queue_polygon(box);
    outline = {pt(0, 1000), pt(1000, -1000), pt(-1000, -1000)};
    queue_polygon(box);
    // enclosing triangle around a wrapped empty window
    outline = {pt(-1000, -1000), pt(1000, -1000), pt(0, 1000)};
    queue_polygon(span(65534, 1, 65534, 1));
    // collinear with the top edge but clear of it, then touching the corner
    outline = {pt(20, 100), pt(60, 100), pt(60, 40)};
    queue_polygon(box);
    outline = {pt(20, 100), pt(100, 100), pt(60, 40)};
    queue_polygon(box);
    // two vertex polygon across the window
    outline = {pt(0, 0), pt(300, 300)};
    queue_polygon(box);
    // extreme coordinates against full, single pixel and far corner windows
    outline = {pt(-32768, -32768), pt(32767, -32768), pt(32767, 32767), pt(-32768, 32767)};
    queue_polygon(span(0, 65535, 0, 65535));
    queue_polygon(span(0, 1, 0, 1));
    queue_polygon(span(65534, 65535, 65534, 65535));

    // outline that winds twice around the window
    outline = {};
    repeat (2) begin
      outline.push_back(pt(-1000, -1000));
      outline.push_back(pt(1000, -1000));
      outline.push_back(pt(0, 1000));
    end
    queue_polygon(box);

    random_start = vertex_queue.size();
    while (vertex_queue.size() < random_start + RANDOM_ITEMS) random_polygon();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // hold until every vertex has gone and every relation has come back
    do @(negedge clk);
    while (vertex_queue.size() != 0 || vertex_valid || relations_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fault_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
